[rtl/core/pointcloud_to_scan_binner_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scan binner
// Property wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINTCLOUD_TO_SCAN_BINNER_ASSERT_SVH
`define POINTCLOUD_TO_SCAN_BINNER_ASSERT_SVH

// Same-cycle implication.
`define PTSB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PTSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ptsb_pkg.sv]
// ----------------------------------------------------------------------------
// ptsb_pkg
// Shared types, constants and the arctangent table of the scan binner.
// ----------------------------------------------------------------------------
package ptsb_pkg;

	localparam int NUM_BINS_DEF = 720;

	localparam int COORD_W = 20;
	localparam int RANGE_W = 20;
	localparam int REFL_W  = 8;
	localparam int ANGLE_W = 16;
	localparam int SCALE_W = 16;
	localparam int RBIN_W  = 10;
	localparam int RAD_W   = 40;

	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS   = 20;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [2:0] REG_MIN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_MAX_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ANGLE_LOW  = 3'd2;
	localparam logic [2:0] REG_ANGLE_HIGH = 3'd3;
	localparam logic [2:0] REG_BIN_SCALE  = 3'd4;

	localparam logic signed [COORD_W-1:0] MIN_HEIGHT_RST = 20'sd0;
	localparam logic signed [COORD_W-1:0] MAX_HEIGHT_RST = 20'sd200;
	localparam logic signed [ANGLE_W-1:0] ANGLE_LOW_RST  = -16'sd16384;
	localparam logic signed [ANGLE_W-1:0] ANGLE_HIGH_RST = 16'sd16384;
	localparam logic [SCALE_W-1:0]        BIN_SCALE_RST  = 16'd1438;

	// Status of the iterative distance and angle unit.
	typedef struct packed {
		logic                       done;
		logic signed [ANGLE_W-1:0]  angle;
		logic [RANGE_W-1:0]         dist_mm;
	} ptsb_res_t;

	// atan(2^-i) in units of 2^32 per turn, truncated.
	function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933405;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335086;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41721;
			5'd15: v = 32'd20860;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2607;
			5'd19: v = 32'd1303;
			5'd20: v = 32'd651;
			5'd21: v = 32'd325;
			5'd22: v = 32'd162;
			5'd23: v = 32'd81;
			5'd24: v = 32'd40;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd2;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/ptsb_iter.sv]
// ----------------------------------------------------------------------------
// ptsb_iter
// Iterative CORDIC vectoring for the point angle, with a bit-serial integer
// square root of x*x+y*y running on the same step counter.
// ----------------------------------------------------------------------------
module ptsb_iter
	import ptsb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [COORD_W-1:0]  x,
	input  logic signed [COORD_W-1:0]  y,
	input  logic [RAD_W-1:0]           rad,
	output ptsb_res_t                  res
);

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [63:0] cx_q;
	logic signed [63:0] cy_q;
	logic [31:0]        cz_q;
	logic               zero_q;
	logic [RAD_W-1:0]   rem_q;
	logic [RAD_W:0]     root_q;
	logic [RAD_W-1:0]   bit_q;

	logic signed [63:0] x_ext;
	logic signed [63:0] y_ext;
	logic signed [63:0] dx;
	logic signed [63:0] dy;
	logic [RAD_W:0]     trial;
	logic [31:0]        z_round;

	// Coordinates enter scaled by 2^40 so the shifted terms keep their precision.
	assign x_ext = {{(64 - COORD_W - 40){x[COORD_W-1]}}, x, 40'd0};
	assign y_ext = {{(64 - COORD_W - 40){y[COORD_W-1]}}, y, 40'd0};
	assign dx    = cy_q >>> cnt_q;
	assign dy    = cx_q >>> cnt_q;
	assign trial = root_q + {1'b0, bit_q};
	assign z_round = cz_q + 32'h0000_8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x == '0) && (y == '0);
			if (x[COORD_W-1]) begin
				cx_q <= -x_ext;
				cy_q <= -y_ext;
				cz_q <= 32'h8000_0000;
			end else begin
				cx_q <= x_ext;
				cy_q <= y_ext;
				cz_q <= 32'h0000_0000;
			end
			rem_q  <= rad;
			root_q <= '0;
			bit_q  <= RAD_W'(1) << (2 * SQRT_STEPS - 2);
		end else if (busy_q) begin
			if (!cy_q[63]) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + atan_entry(cnt_q);
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - atan_entry(cnt_q);
			end
			if (cnt_q < CNT_W'(SQRT_STEPS)) begin
				if ({1'b0, rem_q} >= trial) begin
					rem_q  <= rem_q - trial[RAD_W-1:0];
					root_q <= (root_q >> 1) + {1'b0, bit_q};
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign res.done    = done_q;
	assign res.angle   = zero_q ? '0 : $signed(z_round[31:16]);
	assign res.dist_mm = root_q[RANGE_W-1:0];

endmodule

[rtl/core/pointcloud_to_scan_binner.sv]
// ----------------------------------------------------------------------------
// pointcloud_to_scan_binner
// Insert item: a point passes SQX, SQY, SUM, ITER, WIN, IDX and CMP; one
// outside the height range returns to idle after SQX, one outside the angle
// window after WIN, one past the bin count after IDX. ITER waits for the
// 30-step CORDIC loop of ptsb_iter. Read item: RD then RSP, where the
// result waits while the output register is still full.
// After reset a clearing pass over all NUM_BINS bins (720 by default) empties
// the bin memory; no item is accepted meanwhile, registers take defaults.
// ----------------------------------------------------------------------------
module pointcloud_to_scan_binner
	import ptsb_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// x_mm[19:0], y_mm[39:20], z_mm[59:40], reflect_in[67:60], read_bin[77:68]
	input  logic [79:0]           s_axis_tdata,
	// mode[0]
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// range_mm[19:0], reflect_out[27:20]
	output logic [31:0]           m_axis_tdata,
	// hit[0]
	output logic [0:0]            m_axis_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W   = $clog2(NUM_BINS);
	localparam int ENTRY_W = 1 + RANGE_W + REFL_W;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SQX   = 4'd2;
	localparam logic [3:0] ST_SQY   = 4'd3;
	localparam logic [3:0] ST_SUM   = 4'd4;
	localparam logic [3:0] ST_ITER  = 4'd5;
	localparam logic [3:0] ST_WIN   = 4'd6;
	localparam logic [3:0] ST_IDX   = 4'd7;
	localparam logic [3:0] ST_CMP   = 4'd8;
	localparam logic [3:0] ST_RD    = 4'd9;
	localparam logic [3:0] ST_RSP   = 4'd10;

	logic [3:0]                 state_q;
	logic [IDX_W-1:0]           clr_cnt_q;
	logic signed [COORD_W-1:0]  x_q;
	logic signed [COORD_W-1:0]  y_q;
	logic signed [COORD_W-1:0]  z_q;
	logic [REFL_W-1:0]          refl_q;
	logic [RBIN_W-1:0]          rb_q;
	logic [RAD_W-1:0]           prod_q;
	logic [RAD_W-1:0]           sq_q;
	logic [IDX_W-1:0]           addr_q;
	logic [ENTRY_W-1:0]         rd_q;
	logic                       out_vld_q;
	logic [31:0]                out_data_q;
	logic                       out_hit_q;
	logic signed [COORD_W-1:0]  min_h_q;
	logic signed [COORD_W-1:0]  max_h_q;
	logic signed [ANGLE_W-1:0]  ang_lo_q;
	logic signed [ANGLE_W-1:0]  ang_hi_q;
	logic [SCALE_W-1:0]         scale_q;

	logic [ENTRY_W-1:0]         mem [NUM_BINS];

	ptsb_res_t                  res;
	logic                       in_acc;
	logic                       out_free;
	logic                       out_load;
	logic                       hgt_ok;
	logic                       win_ok;
	logic signed [ANGLE_W-1:0]  ang;
	logic signed [ANGLE_W:0]    diff;
	logic [ANGLE_W-1:0]         off;
	logic [15:0]                idx16;
	logic                       idx_ok;
	logic                       rb_ok;
	logic                       rd_vld;
	logic [RANGE_W-1:0]         rd_range;
	logic [REFL_W-1:0]          rd_refl;
	logic                       upd;
	logic signed [20:0]         mul_a;
	logic signed [20:0]         mul_b;
	logic signed [41:0]         mul_p;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_wa;
	logic [ENTRY_W-1:0]         mem_wd;
	logic [IDX_W-1:0]           mem_ra;
	logic                       cfg_wr;
	logic [2:0]                 reg_sel;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_h_q  <= MIN_HEIGHT_RST;
			max_h_q  <= MAX_HEIGHT_RST;
			ang_lo_q <= ANGLE_LOW_RST;
			ang_hi_q <= ANGLE_HIGH_RST;
			scale_q  <= BIN_SCALE_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MIN_HEIGHT: min_h_q  <= pwdata[COORD_W-1:0];
				REG_MAX_HEIGHT: max_h_q  <= pwdata[COORD_W-1:0];
				REG_ANGLE_LOW:  ang_lo_q <= pwdata[ANGLE_W-1:0];
				REG_ANGLE_HIGH: ang_hi_q <= pwdata[ANGLE_W-1:0];
				REG_BIN_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MIN_HEIGHT: prdata = APB_DATA_W'(min_h_q);
			REG_MAX_HEIGHT: prdata = APB_DATA_W'(max_h_q);
			REG_ANGLE_LOW:  prdata = APB_DATA_W'(ang_lo_q);
			REG_ANGLE_HIGH: prdata = APB_DATA_W'(ang_hi_q);
			REG_BIN_SCALE:  prdata = APB_DATA_W'(scale_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign out_load      = (state_q == ST_RSP) && out_free;

	assign hgt_ok = (z_q >= min_h_q) && (z_q <= max_h_q);
	assign ang    = res.angle;
	assign win_ok = (ang >= ang_lo_q) && (ang <= ang_hi_q);
	assign diff   = (ANGLE_W + 1)'(ang) - (ANGLE_W + 1)'(ang_lo_q);
	assign off    = diff[ANGLE_W-1:0];
	assign idx16  = prod_q[31:16];
	assign idx_ok = 32'(idx16) < 32'(NUM_BINS);
	assign rb_ok  = 32'(rb_q) < 32'(NUM_BINS);

	assign rd_vld   = rd_q[ENTRY_W-1];
	assign rd_range = rd_q[REFL_W +: RANGE_W];
	assign rd_refl  = rd_q[REFL_W-1:0];
	assign upd      = !rd_vld || (res.dist_mm < rd_range);

	// One multiplier serves both squares and the bin index scaling.
	always_comb begin
		unique case (state_q)
			ST_SQX: begin
				mul_a = {x_q[COORD_W-1], x_q};
				mul_b = {x_q[COORD_W-1], x_q};
			end
			ST_SQY: begin
				mul_a = {y_q[COORD_W-1], y_q};
				mul_b = {y_q[COORD_W-1], y_q};
			end
			default: begin
				mul_a = {5'd0, off};
				mul_b = {5'd0, scale_q};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	ptsb_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SUM),
		.x      (x_q),
		.y      (y_q),
		.rad    (sq_q + prod_q),
		.res    (res)
	);

	// ------------------------------------------------------------------
	// Bin memory: valid bit, range and reflectivity in one word
	// ------------------------------------------------------------------
	// The read address stays on the requested bin while the result waits.
	assign mem_ra = ((state_q == ST_RD) || (state_q == ST_RSP)) ? IDX_W'(rb_q) :
		idx16[IDX_W-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		priority if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
		end else if (out_load) begin
			mem_we = rb_ok && rd_vld;
		end else if (state_q == ST_CMP) begin
			mem_we = upd;
			mem_wd = {1'b1, res.dist_mm, refl_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == IDX_W'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= s_axis_tuser[0] ? ST_RD : ST_SQX;
					end
				end
				ST_SQX:  state_q <= hgt_ok ? ST_SQY : ST_IDLE;
				ST_SQY:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ITER;
				ST_ITER: begin
					if (res.done) begin
						state_q <= ST_WIN;
					end
				end
				ST_WIN:  state_q <= win_ok ? ST_IDX : ST_IDLE;
				ST_IDX:  state_q <= idx_ok ? ST_CMP : ST_IDLE;
				ST_CMP:  state_q <= ST_IDLE;
				ST_RD:   state_q <= ST_RSP;
				ST_RSP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= s_axis_tdata[19:0];
			y_q    <= s_axis_tdata[39:20];
			z_q    <= s_axis_tdata[59:40];
			refl_q <= s_axis_tdata[67:60];
			rb_q   <= s_axis_tdata[77:68];
		end
		if (state_q == ST_SQY) begin
			sq_q <= prod_q;
		end
		if ((state_q == ST_SQX) || (state_q == ST_SQY) || (state_q == ST_WIN)) begin
			prod_q <= mul_p[RAD_W-1:0];
		end
		if (state_q == ST_RD) begin
			addr_q <= IDX_W'(rb_q);
		end else if (state_q == ST_IDX) begin
			addr_q <= idx16[IDX_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// A bin that is out of range or empty reads as zero with no hit.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (rb_ok && rd_vld) begin
				out_data_q <= {4'd0, rd_refl, rd_range};
				out_hit_q  <= 1'b1;
			end else begin
				out_data_q <= '0;
				out_hit_q  <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_hit_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`include "pointcloud_to_scan_binner_assert.svh"

	`PTSB_ASSERT_IMPL(a_no_accept_in_clear, state_q == ST_CLEAR, !s_axis_tready, "taken in clear")
	`PTSB_ASSERT_IMPL(a_done_in_iter, res.done, state_q == ST_ITER, "stray done")
	`PTSB_ASSERT_NEXT(a_load_shows, out_load, m_axis_tvalid && (state_q == ST_IDLE), "no result")

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the point cloud to scan binner
// Streams lidar points and bin reads into the block under several register
// settings, with random idling on both stream sides. It keeps its own copy of
// the bins (CORDIC angle, integer square root, nearest point per bin) and
// compares every readout field by field with the oldest expected readout.
// ----------------------------------------------------------------------------
module tb
	import ptsb_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = NUM_BINS_DEF;
	// Cycles to let a point still in the CORDIC loop finish before a register write.
	localparam int SETTLE_CYCLES = 48;

	// atan(2^-i) in units of 2^32 per turn, truncated.
	localparam bit [0:CORDIC_STEPS-1][31:0] ATAN_LUT = {
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
		32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303,
		32'd651, 32'd325, 32'd162, 32'd81, 32'd40,
		32'd20, 32'd10, 32'd5, 32'd2, 32'd1
	};

	typedef struct packed {
		logic                       mode;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic [REFL_W-1:0]          refl;
		logic [RBIN_W-1:0]          rbin;
	} scan_item_t;

	typedef struct packed {
		logic [RANGE_W-1:0] rng;
		logic [REFL_W-1:0]  refl;
		logic               hit;
	} readout_t;

	// Shadow copy of the bin memory and the registers, plus the readouts due.
	class scan_bins;
		bit [RANGE_W-1:0] near_range [NB];
		bit [REFL_W-1:0]  near_refl [NB];
		bit               occupied [NB];
		int               min_h, max_h, ang_lo, ang_hi;
		int unsigned      scale;
		readout_t         readouts_due[$];
		int               errors, n_points, n_binned, n_reads, n_hits, n_checked;

		function new();
			min_h = MIN_HEIGHT_RST;
			max_h = MAX_HEIGHT_RST;
			ang_lo = ANGLE_LOW_RST;
			ang_hi = ANGLE_HIGH_RST;
			scale = BIN_SCALE_RST;
		endfunction

		function void set_reg(logic [2:0] idx, int value);
			logic signed [COORD_W-1:0] h;
			logic signed [ANGLE_W-1:0] a;
			h = value[COORD_W-1:0];
			a = value[ANGLE_W-1:0];
			case (idx)
				REG_MIN_HEIGHT: min_h = h;
				REG_MAX_HEIGHT: max_h = h;
				REG_ANGLE_LOW:  ang_lo = a;
				REG_ANGLE_HIGH: ang_hi = a;
				REG_BIN_SCALE:  scale = value[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		// Vectoring CORDIC on coordinates scaled by 2^40; angle in 1/65536 turn.
		function int cordic_angle(int xi, int yi);
			longint x, y, dx, dy;
			bit [31:0] acc, r;
			if (xi == 0 && yi == 0)
				return 0;
			x = longint'(xi) <<< 40;
			y = longint'(yi) <<< 40;
			acc = 32'h0;
			if (x < 0) begin
				x = -x;
				y = -y;
				acc = 32'h8000_0000;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx;
					y -= dy;
					acc += ATAN_LUT[i];
				end else begin
					x -= dx;
					y += dy;
					acc -= ATAN_LUT[i];
				end
			end
			r = (acc + 32'h8000) >> 16;
			return int'(signed'(r[15:0]));
		endfunction

		function int unsigned planar_dist(int xi, int yi);
			longint unsigned v, res, b;
			v = longint'(xi) * xi + longint'(yi) * yi;
			res = 0;
			b = 64'h1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return int'(res);
		endfunction

		// Bin that a point at (x, y) falls into, or -1 if it is dropped.
		function int bin_for(int xi, int yi);
			int a;
			int unsigned idx;
			a = cordic_angle(xi, yi);
			if (a < ang_lo || a > ang_hi)
				return -1;
			idx = a - ang_lo;
			idx = (idx * scale) >> 16;
			return (idx < NB) ? int'(idx) : -1;
		endfunction

		function void take_item(scan_item_t it);
			readout_t ro;
			int b;
			int unsigned d;
			if (it.mode) begin
				n_reads++;
				ro = '0;
				if (it.rbin < NB && occupied[it.rbin]) begin
					ro.rng = near_range[it.rbin];
					ro.refl = near_refl[it.rbin];
					ro.hit = 1'b1;
					occupied[it.rbin] = 1'b0;
					near_range[it.rbin] = '0;
					near_refl[it.rbin] = '0;
					n_hits++;
				end
				readouts_due.push_back(ro);
				return;
			end
			n_points++;
			if (it.z < min_h || it.z > max_h)
				return;
			b = bin_for(it.x, it.y);
			if (b < 0)
				return;
			d = planar_dist(it.x, it.y);
			// On a tie the stored point stays.
			if (!occupied[b] || d < near_range[b]) begin
				near_range[b] = d;
				near_refl[b] = it.refl;
				occupied[b] = 1'b1;
				n_binned++;
			end
		endfunction

		function void check_readout(readout_t got);
			readout_t want;
			if (readouts_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR %0t: unexpected readout range=%0d refl=%0d hit=%0b",
						$time, got.rng, got.refl, got.hit);
				return;
			end
			want = readouts_due.pop_front();
			n_checked++;
			if (got.rng !== want.rng || got.refl !== want.refl || got.hit !== want.hit) begin
				errors++;
				if (errors <= 10)
					$display("ERROR %0t: range/refl/hit expected %0d/%0d/%0b got %0d/%0d/%0b",
						$time, want.rng, want.refl, want.hit, got.rng, got.refl, got.hit);
			end
		endfunction

		function int pick_full_bin();
			int start;
			start = $urandom_range(0, NB - 1);
			for (int k = 0; k < NB; k++)
				if (occupied[(start + k) % NB])
					return (start + k) % NB;
			return -1;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// x_mm[19:0], y_mm[39:20], z_mm[59:40], reflect_in[67:60], read_bin[77:68]
	logic [79:0]           s_axis_tdata = '0;
	// mode[0]
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// range_mm[19:0], reflect_out[27:20]
	logic [31:0]           m_axis_tdata;
	// hit[0]
	logic [0:0]            m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	scan_bins   scan;
	scan_item_t prev_pt;
	bit         have_prev = 1'b0;
	bit         calm = 1'b0;
	int         rx_hold = 0;
	int         n_settings = 0;

	pointcloud_to_scan_binner dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	// Result side: random stalls after each transfer, occasional spontaneous
	// stalls, and a long hold-off whenever the stimulus asks for one.
	initial begin : readout_sink
		int stall_left;
		readout_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[RANGE_W-1:0], m_axis_tdata[RANGE_W+REFL_W-1:RANGE_W],
					m_axis_tuser[0]};
				scan.check_readout(got);
				stall_left = calm ? 0 : $urandom_range(0, 8);
			end else if (stall_left == 0 && !calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(1, 8);
			end
			if (rx_hold > 0) begin
				stall_left = rx_hold;
				rx_hold = 0;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic push_item(scan_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.mode;
		s_axis_tdata <= {2'b00, it.rbin, it.refl, it.z, it.y, it.x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		scan.take_item(it);
	endtask

	task automatic send_point(int x, int y, int z, logic [REFL_W-1:0] r);
		scan_item_t it;
		it = '0;
		it.x = x;
		it.y = y;
		it.z = z;
		it.refl = r;
		push_item(it);
	endtask

	task automatic send_read(int b);
		scan_item_t it;
		it = '0;
		it.mode = 1'b1;
		it.rbin = b;
		push_item(it);
	endtask

	task automatic wait_readouts();
		s_axis_tvalid <= 1'b0;
		while (scan.readouts_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		scan.set_reg(idx, value);
	endtask

	// Registers change only with nothing in flight.
	task automatic configure(int min_h, int max_h, int lo, int hi, int scale);
		wait_readouts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_MIN_HEIGHT, min_h);
		write_reg(REG_MAX_HEIGHT, max_h);
		write_reg(REG_ANGLE_LOW, lo);
		write_reg(REG_ANGLE_HIGH, hi);
		write_reg(REG_BIN_SCALE, scale);
		n_settings++;
	endtask

	function automatic scan_item_t random_point();
		scan_item_t it;
		int sel, span, ang, rad;
		real th;
		it = '0;
		it.refl = $urandom;
		it.rbin = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			it.x = $urandom;
			it.y = $urandom;
			it.z = $urandom;
			return it;
		end
		if (sel < 40 && have_prev) begin
			// Same point again (tie) or the same direction at half the distance.
			it.x = (sel < 30) ? prev_pt.x : prev_pt.x >>> 1;
			it.y = (sel < 30) ? prev_pt.y : prev_pt.y >>> 1;
			it.z = prev_pt.z;
			return it;
		end
		if (scan.min_h <= scan.max_h)
			it.z = scan.min_h + int'($urandom_range(0, scan.max_h - scan.min_h));
		else
			it.z = $urandom;
		span = scan.ang_hi - scan.ang_lo;
		if (span >= 0)
			ang = scan.ang_lo + int'($urandom_range(0, span));
		else
			ang = int'($urandom_range(0, 65535)) - 32768;
		rad = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 524287);
		th = ang * 6.283185307179586 / 65536.0;
		it.x = int'(rad * $cos(th));
		it.y = int'(rad * $sin(th));
		return it;
	endfunction

	function automatic scan_item_t random_read();
		scan_item_t it;
		int sel, b;
		it.mode = 1'b1;
		it.x = $urandom;
		it.y = $urandom;
		it.z = $urandom;
		it.refl = $urandom;
		sel = $urandom_range(0, 9);
		b = scan.pick_full_bin();
		if (sel < 7 && b >= 0)
			it.rbin = b;
		else if (sel < 9)
			it.rbin = $urandom_range(0, NB - 1);
		else
			it.rbin = $urandom_range(0, 1023);
		return it;
	endfunction

	task automatic run_random(int n);
		scan_item_t it;
		repeat (n) begin
			it = ($urandom_range(0, 99) < 30) ? random_read() : random_point();
			push_item(it);
			if (!it.mode) begin
				prev_pt = it;
				have_prev = 1'b1;
			end
		end
	endtask

	initial begin : stimulus
		scan = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings: the block first empties its bins.
		send_read(0);
		send_point(0, 0, 0, 8'h5a);
		send_point(524287, 0, 200, 8'hff);
		send_read(scan.bin_for(0, 0));
		send_read(scan.bin_for(0, 0));
		send_point(0, -524288, 0, 8'h00);
		send_point(0, 524287, 100, 8'hff);
		send_point(-524288, -524288, 0, 8'h11);
		send_point(1000, 0, -524288, 8'h22);
		send_point(1000, 0, 524287, 8'h33);
		send_point(1000, 0, -1, 8'h44);
		send_point(1000, 0, 201, 8'h55);
		send_point(1000, 1000, 50, 8'h01);
		send_point(1000, 1000, 50, 8'h02);
		send_point(524287, -524288, 200, 8'haa);
		send_read(scan.bin_for(0, -524288));
		send_read(scan.bin_for(0, 524287));
		send_read(scan.bin_for(1000, 1000));
		send_read(scan.bin_for(524287, -524288));
		send_read(NB);
		send_read(1023);

		// Full turn over all bins; a point straight behind lands in the first bin.
		configure(-100, 2000, -32768, 32767, 720);
		send_point(-5000, 0, 0, 8'h77);
		send_read(scan.bin_for(-5000, 0));
		run_random(300);

		// Widest heights and window with the largest scale, no idling.
		configure(-524288, 524287, -32768, 32767, 65535);
		calm = 1'b1;
		run_random(200);
		calm = 1'b0;

		// The result side holds off while reads keep coming, then the sender
		// pauses until every readout has arrived.
		configure(0, 524287, -8192, 24576, 1438);
		run_random(120);
		rx_hold = 400;
		calm = 1'b1;
		repeat (24)
			push_item(random_read());
		calm = 1'b0;
		wait_readouts();
		run_random(130);

		// A zero scale puts every kept point into the first bin.
		configure(-524288, 0, -4000, 4000, 0);
		run_random(150);

		// Empty height range, then an empty angle window.
		configure(10, 5, -32768, 32767, 720);
		run_random(60);
		configure(-1000, 1000, 2000, -2000, 720);
		run_random(60);

		configure(MIN_HEIGHT_RST, MAX_HEIGHT_RST, ANGLE_LOW_RST, ANGLE_HIGH_RST,
			BIN_SCALE_RST);
		run_random(200);

		wait_readouts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (scan.readouts_due.size() > 0) begin
			$display("ERROR: %0d readouts never arrived", scan.readouts_due.size());
			scan.errors += scan.readouts_due.size();
		end
		$display("Covered %0d points (%0d stored into bins) and %0d bin reads (%0d hits)",
			scan.n_points, scan.n_binned, scan.n_reads, scan.n_hits);
		$display("over %0d register settings; %0d readouts checked, %0d errors.",
			n_settings + 1, scan.n_checked, scan.errors);
		if (scan.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
